// ===== hdl/tccw_pkg.sv =====
// Shared types and constants for the text console cursor writer.
package tccw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [CELL_W-1:0] cell_t;

  localparam opcode_t OP_PUT   = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_SPACE     = 8'h20;

  localparam attr_t ATTR_RESET = 8'h0f;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

endpackage

// ===== hdl/tccw_cell_store.sv =====
// Character cell memory: one write port, one registered read port.
module tccw_cell_store #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  tccw_pkg::cell_t       wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output tccw_pkg::cell_t       rd_data
);

  tccw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/text_console_cursor_writer.sv =====
// Text console writer top level: cell memory, cursor and sweep sequencer.
//
// Usage
//   Request channel: drive in_opcode, in_char_code and in_cell_index with
//   start high; the request is taken at a rising edge where busy is low.
//   Opcodes: put character (newline, backspace and wrap handled), read one
//   cell, clear screen. Unused opcode returns a result and changes nothing.
//   Result channel: out_strobe is high for one cycle with out_cursor_pos
//   (linear cursor after the request) and out_cell_value (cell for a read,
//   zero otherwise). The receiver cannot stall; every result is taken.
//   Config: cfg_wr_en/cfg_wr_data write the text attribute; write it only
//   while no request is in flight. Resets to white on black.
// Timing
//   Put without scroll and out-of-range read: result in the cycle after the
//   request edge, busy stays low. In-range read: busy during the registered
//   memory read. Scroll: each row below the top moves up one row, then the
//   bottom row is zeroed; clear zeroes every cell. The strobe comes once busy
//   is low again. One cell per cycle through the single memory port pair.
// Reset
//   rst_n (sync, active low) homes the cursor and starts a zero fill of all
//   ROWS*COLS cells; busy stays high until it ends, no result given.
module text_console_cursor_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  tccw_pkg::opcode_t            in_opcode,
  input  tccw_pkg::char_t              in_char_code,
  input  logic [tccw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                         out_strobe,
  output logic [tccw_pkg::POS_W-1:0]   out_cursor_pos,
  output tccw_pkg::cell_t              out_cell_value,
  input  logic                         cfg_wr_en,
  input  tccw_pkg::attr_t              cfg_wr_data
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int LIN_W  = (ADDR_W > tccw_pkg::POS_W) ? ADDR_W : tccw_pkg::POS_W;
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [LIN_W-1:0]  LIN_BOTTOM = LIN_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  // one bit wider: a power-of-two cell count must not wrap to zero
  localparam logic [LIN_W:0]    LIN_CELLS = (LIN_W+1)'(CELLS);
  localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(CELLS - SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_COLUMNS);

  tccw_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;        // sweep pointer for scroll and fill
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [LIN_W-1:0]  lin_r, lin_nxt;        // row * columns + column, kept in step
  logic              reply_r, reply_nxt;    // fill ends a request (not a reset)
  tccw_pkg::attr_t   attr_r;

  logic                        out_valid_r;
  logic [tccw_pkg::POS_W-1:0]  out_pos_r;
  tccw_pkg::cell_t             out_val_r;

  logic              emit;
  tccw_pkg::cell_t   emit_val;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  tccw_pkg::cell_t   wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  tccw_pkg::cell_t   rd_data;

  tccw_cell_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: decode a request in idle, then sweep cells one per cycle.
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    lin_nxt   = lin_r;
    reply_nxt = reply_r;
    emit      = 1'b0;
    emit_val  = '0;
    wr_en     = 1'b0;
    wr_addr   = lin_r[ADDR_W-1:0];
    wr_data   = {attr_r, in_char_code};
    rd_en     = 1'b0;
    rd_addr   = ptr_r + ROW_STEP;

    unique case (state_r)
      tccw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_opcode)
            tccw_pkg::OP_PUT: begin
              priority if (in_char_code == tccw_pkg::CH_NEWLINE) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  row_nxt   = ROW_LAST;
                  lin_nxt   = LIN_BOTTOM;
                  ptr_nxt   = '0;
                  state_nxt = tccw_pkg::ST_SCROLL;
                end else begin
                  row_nxt = row_r + ROW_W'(1);
                  lin_nxt = lin_r - LIN_W'(col_r) + LIN_W'(SCREEN_COLUMNS);
                  emit    = 1'b1;
                end
              end else if (in_char_code == tccw_pkg::CH_BACKSPACE) begin
                // backspace at column zero is ignored
                if (col_r != '0) begin
                  col_nxt = col_r - COL_W'(1);
                  lin_nxt = lin_r - LIN_W'(1);
                  wr_en   = 1'b1;
                  wr_addr = lin_nxt[ADDR_W-1:0];
                  wr_data = {attr_r, tccw_pkg::CH_SPACE};
                end
                emit = 1'b1;
              end else begin
                wr_en = 1'b1;
                if (col_r == COL_LAST) begin
                  col_nxt = '0;
                  if (row_r == ROW_LAST) begin
                    row_nxt   = ROW_LAST;
                    lin_nxt   = LIN_BOTTOM;
                    ptr_nxt   = '0;
                    state_nxt = tccw_pkg::ST_SCROLL;
                  end else begin
                    row_nxt = row_r + ROW_W'(1);
                    lin_nxt = lin_r + LIN_W'(1);
                    emit    = 1'b1;
                  end
                end else begin
                  col_nxt = col_r + COL_W'(1);
                  lin_nxt = lin_r + LIN_W'(1);
                  emit    = 1'b1;
                end
              end
            end
            tccw_pkg::OP_READ: begin
              if ((LIN_W+1)'(in_cell_index) < LIN_CELLS) begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(in_cell_index);
                state_nxt = tccw_pkg::ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            tccw_pkg::OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              lin_nxt   = '0;
              ptr_nxt   = '0;
              reply_nxt = 1'b1;
              state_nxt = tccw_pkg::ST_FILL;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      tccw_pkg::ST_READ: begin
        emit      = 1'b1;
        emit_val  = rd_data;
        state_nxt = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_SCROLL: begin
        // read cell ptr+columns, write last cycle's data one row up
        rd_en = (ptr_r != MOVE_LAST);
        if (ptr_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = ptr_r - ADDR_W'(1);
          wr_data = rd_data;
        end
        if (ptr_r == MOVE_LAST) begin
          reply_nxt = 1'b1;
          state_nxt = tccw_pkg::ST_FILL;   // bottom row zeroed from here
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      tccw_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = '0;
        if (ptr_r == ADDR_LAST) begin
          emit      = reply_r;
          state_nxt = tccw_pkg::ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_FILL;   // zero the whole screen after reset
      ptr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      lin_r       <= '0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      lin_r       <= lin_nxt;
      reply_r     <= emit ? 1'b0 : reply_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r <= lin_nxt[tccw_pkg::POS_W-1:0];
      out_val_r <= emit_val;
    end
  end

  assign busy           = (state_r != tccw_pkg::ST_IDLE);
  assign out_strobe     = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_value = out_val_r;

  // Checks
  a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_LAST) && (row_r <= ROW_LAST) &&
    (lin_r == LIN_W'(row_r) * LIN_W'(SCREEN_COLUMNS) + LIN_W'(col_r)))
    else $error("cursor linear position out of step with row and column");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a request is still running");

  a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == tccw_pkg::OP_READ) |=>
      (out_strobe || state_r == tccw_pkg::ST_READ))
    else $error("read request neither answered nor waiting on memory");

  a_value_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_cell_value != '0) |-> ($past(state_r) == tccw_pkg::ST_READ))
    else $error("non-zero cell value on a result that is not a read");

endmodule

// ===== sim/console_screen_checker.sv =====
`timescale 1ns / 100ps
// Screen/cursor predictor and result checker for the text console writer.
module console_screen_checker #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  tccw_pkg::opcode_t          in_opcode,
  input  tccw_pkg::char_t            in_char_code,
  input  logic [tccw_pkg::IDX_W-1:0] in_cell_index,
  input  logic                       out_strobe,
  input  logic [tccw_pkg::POS_W-1:0] out_cursor_pos,
  input  tccw_pkg::cell_t            out_cell_value,
  input  logic                       cfg_wr_en,
  input  tccw_pkg::attr_t            cfg_wr_data,
  output int                         fail_count,
  output int                         awaited_count
);

  localparam int CELL_COUNT   = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [tccw_pkg::POS_W-1:0] cursor_pos;
    tccw_pkg::cell_t            cell_value;
  } console_result_t;

  tccw_pkg::cell_t screen_copy [CELL_COUNT];
  int unsigned     cursor_col;
  int unsigned     cursor_row;
  tccw_pkg::attr_t text_attr;
  console_result_t awaited_results [$];
  console_result_t oldest_result;
  int              mismatches;

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: mismatch: %s", $time, what);
  endtask

  // Work out the cursor/cell outcome of one accepted request
  task automatic predict_request(tccw_pkg::opcode_t op, tccw_pkg::char_t ch,
                                 logic [tccw_pkg::IDX_W-1:0] idx);
    console_result_t res;
    res = '0;
    case (op)
      tccw_pkg::OP_PUT: begin
        if (ch == tccw_pkg::CH_BACKSPACE) begin
          // column 0: ignored
          if (cursor_col != 0) begin
            cursor_col--;
            screen_copy[cursor_row * SCREEN_COLUMNS + cursor_col] =
              {text_attr, tccw_pkg::CH_SPACE};
          end
        end else begin
          if (ch == tccw_pkg::CH_NEWLINE) begin
            cursor_col = 0;
            cursor_row++;
          end else begin
            screen_copy[cursor_row * SCREEN_COLUMNS + cursor_col] = {text_attr, ch};
            cursor_col++;
          end
          if (cursor_col >= SCREEN_COLUMNS) begin
            cursor_col = 0;
            cursor_row++;
          end
          if (cursor_row >= SCREEN_ROWS) begin
            for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
              screen_copy[i] = screen_copy[i + SCREEN_COLUMNS];
            for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
              screen_copy[i] = '0;
            cursor_row = SCREEN_ROWS - 1;
          end
        end
      end
      tccw_pkg::OP_READ: begin
        if (idx < CELL_COUNT) res.cell_value = screen_copy[idx];
      end
      tccw_pkg::OP_CLEAR: begin
        foreach (screen_copy[i]) screen_copy[i] = '0;
        cursor_col = 0;
        cursor_row = 0;
      end
      default: ;
    endcase
    res.cursor_pos = tccw_pkg::POS_W'(cursor_row * SCREEN_COLUMNS + cursor_col);
    awaited_results.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (screen_copy[i]) screen_copy[i] = '0;
      cursor_col = 0;
      cursor_row = 0;
      text_attr  = tccw_pkg::ATTR_RESET;
      awaited_results.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result pos %0d cell %h",
                                  out_cursor_pos, out_cell_value));
        end else begin
          oldest_result = awaited_results.pop_front();
          if (out_cursor_pos !== oldest_result.cursor_pos)
            note_mismatch($sformatf("cursor_pos exp %0d got %0d",
                                    oldest_result.cursor_pos, out_cursor_pos));
          if (out_cell_value !== oldest_result.cell_value)
            note_mismatch($sformatf("cell_value exp %h got %h",
                                    oldest_result.cell_value, out_cell_value));
        end
      end
      if (cfg_wr_en) text_attr = cfg_wr_data;
      if (start && !busy) predict_request(in_opcode, in_char_code, in_cell_index);
    end
    fail_count    <= mismatches;
    awaited_count <= awaited_results.size();
  end

endmodule

// ===== sim/text_console_cursor_writer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, attribute writes and verdict.
module text_console_cursor_writer_tb;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int BURST_REQUESTS = 200;
  localparam int LONG_GAP_MAX   = 60;
  // scroll and clear sweep every cell once, plus a little overhead
  localparam int SWEEP_CYCLES   = CELL_COUNT + 2;
  localparam int DRAIN_CYCLES   = 2 * SWEEP_CYCLES;
  // each burst may overrun its quota by up to one line; 1400 requests bounds it
  localparam int REQUEST_BOUND  = 1400;
  localparam longint CYCLE_LIMIT =
    3 * longint'(REQUEST_BOUND) * (2 * SWEEP_CYCLES + LONG_GAP_MAX) + SWEEP_CYCLES;

  localparam tccw_pkg::opcode_t OP_UNUSED = 2'd3;

  typedef logic [tccw_pkg::IDX_W-1:0] cell_index_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  tccw_pkg::opcode_t          in_opcode;
  tccw_pkg::char_t            in_char_code;
  cell_index_t                in_cell_index;
  logic                       out_strobe;
  logic [tccw_pkg::POS_W-1:0] out_cursor_pos;
  tccw_pkg::cell_t            out_cell_value;
  logic                       cfg_wr_en;
  tccw_pkg::attr_t            cfg_wr_data;
  int                         fail_count;
  int                         awaited_count;

  int unsigned      requests_sent;
  bit               no_idle;
  longint           cycle_count;

  always #(HALF_PERIOD) clk = ~clk;

  text_console_cursor_writer #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_strobe    (out_strobe),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_value(out_cell_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Predicts and compares every result; the top only reads the counts back.
  console_screen_checker #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) screen_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_strobe    (out_strobe),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_value(out_cell_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  function automatic tccw_pkg::char_t any_char();
    return tccw_pkg::char_t'($urandom_range(0, 255));
  endfunction

  function automatic cell_index_t any_index();
    return cell_index_t'($urandom_range(0, (1 << tccw_pkg::IDX_W) - 1));
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, LONG_GAP_MAX);
  endfunction

  // Reads lean towards the rows the cursor tends to occupy: the top rows
  // before the first scroll, the bottom rows after it.
  function automatic cell_index_t pick_read_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return cell_index_t'($urandom_range(CELL_COUNT - 3 * SCREEN_COLUMNS,
                                                         CELL_COUNT - 1));
    if (roll < 55) return cell_index_t'($urandom_range(0, 3 * SCREEN_COLUMNS - 1));
    if (roll < 90) return cell_index_t'($urandom_range(0, CELL_COUNT - 1));
    // beyond the grid: must read back as zero
    return cell_index_t'($urandom_range(CELL_COUNT, (1 << tccw_pkg::IDX_W) - 1));
  endfunction

  // Present one request and hold it until the block takes it (start high,
  // busy low at the edge). start stays high when the next request follows
  // straight on, so it is never lowered and raised within one step.
  task automatic send_request(tccw_pkg::opcode_t op, tccw_pkg::char_t ch,
                              cell_index_t idx);
    int unsigned gap;
    start         <= 1'b1;
    in_opcode     <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    requests_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every awaited result is in and busy is low.
  // The first edge lets the checker's count catch up with the last request.
  task automatic wait_for_idle();
    start <= 1'b0;
    do @(posedge clk); while (awaited_count != 0 || busy);
  endtask

  task automatic write_attribute(tccw_pkg::attr_t attr);
    wait_for_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic built from well-formed console text: lines of characters
  // (mostly short, some long enough to wrap) ended by newline, reads of
  // cells in between, plus the odd clear, unused opcode and backspace run.
  task automatic random_burst(int unsigned quota);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    target = requests_sent + quota;
    while (requests_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12) : $urandom_range(70, 100);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0)
            send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, any_index());
          else
            send_request(tccw_pkg::OP_PUT, any_char(), any_index());
        end
        if ($urandom_range(0, 9) != 0)
          send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, any_index());
        repeat ($urandom_range(0, 3))
          send_request(tccw_pkg::OP_READ, any_char(), pick_read_index());
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6))
          send_request(tccw_pkg::OP_READ, any_char(), pick_read_index());
      end else if (kind < 83) begin
        send_request(tccw_pkg::OP_CLEAR, any_char(), any_index());
      end else if (kind < 86) begin
        send_request(OP_UNUSED, any_char(), any_index());
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, any_index());
      end
    end
    no_idle = 1'b0;
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = tccw_pkg::OP_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    requests_sent = 0;
    no_idle       = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // the block zero-fills its cell store after reset; let that finish
    wait_for_idle();

    // Directed requests, reset attribute (white on black)
    send_request(tccw_pkg::OP_READ, 8'hff, '0);         // cell 0 is zero after reset
    send_request(tccw_pkg::OP_PUT, 8'h41, '1);          // plain character
    send_request(tccw_pkg::OP_PUT, 8'h00, '0);          // lowest byte
    send_request(tccw_pkg::OP_PUT, 8'hff, '0);          // highest byte
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, '0);  // back one, blank
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(2));   // the blanked cell
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(0));
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, '0);    // column 0 of row 1
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, '1);  // column 0: ignored
    send_request(tccw_pkg::OP_PUT, 8'h07, '0);          // control code stored as is
    send_request(tccw_pkg::OP_PUT, 8'h1b, '0);
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(SCREEN_COLUMNS));
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(CELL_COUNT - 1));
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(CELL_COUNT));  // past the grid
    send_request(tccw_pkg::OP_READ, 8'h00, '1);         // top of the index range
    send_request(OP_UNUSED, 8'h55, cell_index_t'(1));   // no effect, zero cell
    send_request(OP_UNUSED, 8'haa, cell_index_t'(2046));
    send_request(tccw_pkg::OP_CLEAR, 8'h00, '0);        // blank all, home cursor
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(0));
    send_request(tccw_pkg::OP_READ, 8'h00, cell_index_t'(SCREEN_COLUMNS + 1));

    // Random phases, each under its own attribute; extremes first
    write_attribute(8'hff);
    random_burst(BURST_REQUESTS);
    write_attribute(8'h00);
    random_burst(BURST_REQUESTS);
    write_attribute(tccw_pkg::attr_t'($urandom_range(1, 254)));
    random_burst(BURST_REQUESTS / 2);
    // hold off until the block has answered everything, then carry on
    wait_for_idle();
    random_burst(BURST_REQUESTS / 2);
    write_attribute(tccw_pkg::attr_t'($urandom_range(0, 255)));
    random_burst(BURST_REQUESTS);

    // Drain: catch stray results after the last expected one
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (awaited_count != 0) $display("%0d results never arrived", awaited_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
